// ----- rtl/core/text_line_sorter_core_macros.svh -----
// Assertion macros for the line sorter RTL.
// Each check is sampled on clk and held off while arst_n is low.
`ifndef TEXT_LINE_SORTER_CORE_MACROS_SVH
`define TEXT_LINE_SORTER_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TLS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication check failed");
`define TLS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`define TLS_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("invariant check failed");
`else
`define TLS_ASSERT_IMP(lbl, ante, cons)
`define TLS_ASSERT_NEXT(lbl, ante, cons)
`define TLS_ASSERT_ALWAYS(lbl, cond)
`endif
`endif

// ----- rtl/core/tls_pkg.sv -----
// ----------------------------------------------------------------------------
// tls_pkg
// Constants, types and helpers shared by the text line sorter.
// ----------------------------------------------------------------------------
package tls_pkg;

	localparam int MAX_LINES    = 256;
	localparam int MAX_LINE_LEN = 128;

	localparam int LW     = $clog2(MAX_LINES);          // line index
	localparam int CNT_W  = $clog2(MAX_LINES + 1);      // line count
	localparam int OW     = $clog2(MAX_LINE_LEN);       // byte offset
	localparam int LEN_W  = $clog2(MAX_LINE_LEN + 1);   // line length
	localparam int ADDR_W = LW + OW;                    // line store address
	localparam int KEY_W  = 32;
	localparam int CFG_N  = 2;
	localparam int CFG_IW = 1;
	localparam int CFG_DW = 1;

	localparam logic [CFG_IW-1:0] CFG_NUMERIC = 1'd0;
	localparam logic [CFG_IW-1:0] CFG_REVERSE = 1'd1;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_FETCH = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_S_CUR,
		ST_S_CUR2,
		ST_S_CHK,
		ST_S_PREV,
		ST_S_PREVD,
		ST_S_BA,
		ST_S_BB,
		ST_S_BC,
		ST_S_DEC,
		ST_S_PLACE,
		ST_RD_ORD,
		ST_RD_LINE,
		ST_RD_OUT
	} state_t;

	typedef enum logic [1:0] {
		KP_SKIP,
		KP_DIGITS,
		KP_DONE
	} key_phase_t;

	function automatic logic [7:0] fold_case(input logic [7:0] c);
		fold_case = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
	endfunction

endpackage

// ----- rtl/core/tls_if.sv -----
// ----------------------------------------------------------------------------
// tls_item_if / tls_result_if
// Valid/ready channels carrying request and result words of the sorter.
// ----------------------------------------------------------------------------
interface tls_item_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] in_byte;
	logic       end_of_line;

	modport source (output valid, req_type, in_byte, end_of_line, input ready);
	modport sink   (input valid, req_type, in_byte, end_of_line, output ready);
endinterface

interface tls_result_if;
	logic       valid;
	logic       ready;
	logic       out_valid;
	logic [7:0] out_byte;
	logic       out_end_of_line;
	logic       out_end_of_set;
	logic       overflow_flag;

	modport source (output valid, out_valid, out_byte, out_end_of_line, out_end_of_set,
		overflow_flag, input ready);
	modport sink   (input valid, out_valid, out_byte, out_end_of_line, out_end_of_set,
		overflow_flag, output ready);
endinterface

// ----- rtl/core/text_line_sorter_core.sv -----
// Text line sorter. Load words (req_type 0) each store one byte of the
// current line; end_of_line closes it. Fetch words (req_type 1) return the
// stored lines in sorted order, one byte per word, through the order, length
// and line store memory ports. The first fetch after any load runs an
// insertion sort on a single shared compare unit that walks two lines byte by
// byte through the one read port of the line store. Order is case-insensitive
// ASCII, optionally by leading integer first (the key is built as bytes load),
// optionally reversed; equal lines keep load order.
// Dropped bytes and lines set a sticky overflow flag, cleared by reset only.
// ----------------------------------------------------------------------------
// text_line_sorter_core
// Line store, numeric key builder, insertion sort sequencer and readout.
// ----------------------------------------------------------------------------
`include "text_line_sorter_core_macros.svh"

module text_line_sorter_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [tls_pkg::CFG_IW-1:0]   cfg_index,
	input  logic [tls_pkg::CFG_DW-1:0]   cfg_wdata,
	tls_item_if.sink                     item,
	tls_result_if.source                 result
);
	import tls_pkg::*;

	// memories, undefined until written
	logic [7:0]       store_mem [MAX_LINES * (2 ** OW)];
	logic [LEN_W-1:0] len_mem   [MAX_LINES];
	logic [KEY_W-1:0] key_mem   [MAX_LINES];
	logic [LW-1:0]    ord_mem   [MAX_LINES];

	logic [7:0]       store_rdata_q;
	logic [LEN_W-1:0] len_rdata_q;
	logic [KEY_W-1:0] key_rdata_q;
	logic [LW-1:0]    ord_rdata_q;

	state_t state_q, state_d;

	logic             numeric_q, reverse_q;
	logic [CNT_W-1:0] line_count_q;
	logic             line_open_q;
	logic [LEN_W-1:0] open_len_q;
	logic             sorted_q;
	logic             ovf_q;
	logic [CNT_W-1:0] read_line_q;
	logic [OW-1:0]    read_off_q;

	key_phase_t       kphase_q;
	logic             kneg_q;
	logic [KEY_W-1:0] kmag_q;

	logic [CNT_W-1:0] i_q;
	logic [LW-1:0]    j_q;
	logic [LW-1:0]    prev_q;
	logic [LEN_W-1:0] cur_len_q, prev_len_q;
	logic [KEY_W-1:0] cur_key_q;
	logic [LEN_W-1:0] k_q;
	logic [7:0]       byte_a_q;
	logic             lt_q, gt_q;

	logic             res_v_q, res_ov_q, res_eol_q, res_eos_q;
	logic [7:0]       res_byte_q;

	// combinational control
	logic              accept, do_load, do_fetch;
	logic              store_we, meta_we, ord_we;
	logic [ADDR_W-1:0] store_waddr, store_raddr;
	logic [LW-1:0]     line_raddr, ord_raddr, ord_waddr, ord_wdata;
	logic [LEN_W-1:0]  cur_len, new_len, min_len;
	logic              room;
	key_phase_t        kphase_d;
	logic              kneg_d;
	logic [KEY_W-1:0]  kmag_d, key_d;
	logic [KEY_W+3:0]  mag_x10;
	logic              is_digit, is_ws, is_sign;
	logic [7:0]        fa, fb;
	logic              shift_up, last_byte;

	assign item.ready = (state_q == ST_IDLE) && (!res_v_q || result.ready);
	assign accept     = item.valid && item.ready;
	assign do_load    = accept && (item.req_type == REQ_LOAD);
	assign do_fetch   = accept && (item.req_type == REQ_FETCH);

	assign result.valid           = res_v_q;
	assign result.out_valid       = res_ov_q;
	assign result.out_byte        = res_byte_q;
	assign result.out_end_of_line = res_eol_q;
	assign result.out_end_of_set  = res_eos_q;
	assign result.overflow_flag   = ovf_q;

	// load path: current length, room check, key builder
	assign cur_len  = line_open_q ? open_len_q : '0;
	assign new_len  = cur_len + LEN_W'(1);
	assign room     = cur_len < LEN_W'(MAX_LINE_LEN);
	assign is_digit = item.in_byte >= 8'h30 && item.in_byte <= 8'h39;
	assign is_ws    = item.in_byte == 8'h20 || (item.in_byte >= 8'h09 && item.in_byte <= 8'h0D);
	assign is_sign  = item.in_byte == 8'h2B || item.in_byte == 8'h2D;
	assign mag_x10  = ({4'b0, (line_open_q ? kmag_q : '0)} * (KEY_W+4)'(10))
		+ (KEY_W+4)'(item.in_byte - 8'h30);

	always_comb begin
		kphase_d = line_open_q ? kphase_q : KP_SKIP;
		kneg_d   = line_open_q ? kneg_q : 1'b0;
		kmag_d   = line_open_q ? kmag_q : '0;
		case (kphase_d)
			KP_SKIP: begin
				if (is_ws) begin
					kphase_d = KP_SKIP;
				end else if (is_sign) begin
					kneg_d   = (item.in_byte == 8'h2D);
					kphase_d = KP_DIGITS;
				end else if (is_digit) begin
					kmag_d   = KEY_W'(item.in_byte - 8'h30);
					kphase_d = KP_DIGITS;
				end else begin
					kphase_d = KP_DONE;
				end
			end
			KP_DIGITS: begin
				if (is_digit) begin
					// clamp at two to the 31st, the largest magnitude a key can need
					kmag_d = (mag_x10 > (KEY_W+4)'(33'h80000000)) ? 32'h80000000
						: mag_x10[KEY_W-1:0];
				end else begin
					kphase_d = KP_DONE;
				end
			end
			default: kphase_d = KP_DONE;
		endcase
		if (kneg_d)
			key_d = -kmag_d;
		else
			key_d = kmag_d[KEY_W-1] ? 32'h7FFFFFFF : kmag_d;
	end

	assign store_we    = do_load && (line_count_q < CNT_W'(MAX_LINES)) && room;
	assign meta_we     = store_we;
	assign store_waddr = {line_count_q[LW-1:0], cur_len[OW-1:0]};

	// sort compare helpers
	assign min_len   = (prev_len_q < cur_len_q) ? prev_len_q : cur_len_q;
	assign fa        = fold_case(byte_a_q);
	assign fb        = fold_case(store_rdata_q);
	assign shift_up  = reverse_q ? lt_q : gt_q;
	assign last_byte = (LEN_W'(read_off_q) + LEN_W'(1)) >= len_rdata_q;

	// sequencer: next state and memory addressing
	always_comb begin
		state_d     = state_q;
		store_raddr = {prev_q, k_q[OW-1:0]};
		line_raddr  = prev_q;
		ord_raddr   = read_line_q[LW-1:0];
		ord_we      = 1'b0;
		ord_waddr   = j_q;
		ord_wdata   = prev_q;
		case (state_q)
			ST_IDLE: begin
				if (do_fetch)
					state_d = sorted_q ? ST_RD_ORD : ST_S_CUR;
			end
			ST_S_CUR: begin
				line_raddr = i_q[LW-1:0];
				state_d    = (i_q == line_count_q) ? ST_RD_ORD : ST_S_CUR2;
			end
			ST_S_CUR2: state_d = ST_S_CHK;
			ST_S_CHK: begin
				ord_raddr = j_q - LW'(1);
				state_d   = (j_q == '0) ? ST_S_PLACE : ST_S_PREV;
			end
			ST_S_PREV: begin
				line_raddr = ord_rdata_q;
				state_d    = ST_S_PREVD;
			end
			ST_S_PREVD: begin
				if (numeric_q && key_rdata_q != cur_key_q)
					state_d = ST_S_DEC;
				else
					state_d = ST_S_BA;
			end
			ST_S_BA: begin
				store_raddr = {prev_q, k_q[OW-1:0]};
				state_d     = (k_q == min_len) ? ST_S_DEC : ST_S_BB;
			end
			ST_S_BB: begin
				store_raddr = {i_q[LW-1:0], k_q[OW-1:0]};
				state_d     = ST_S_BC;
			end
			ST_S_BC: state_d = (fa != fb) ? ST_S_DEC : ST_S_BA;
			ST_S_DEC: begin
				// move the line that sorts after the new one up one slot, else drop the new line here
				ord_we  = shift_up;
				state_d = shift_up ? ST_S_CHK : ST_S_PLACE;
			end
			ST_S_PLACE: begin
				ord_we    = 1'b1;
				ord_wdata = i_q[LW-1:0];
				state_d   = ST_S_CUR;
			end
			ST_RD_ORD: begin
				state_d = (read_line_q >= line_count_q) ? ST_IDLE : ST_RD_LINE;
			end
			ST_RD_LINE: begin
				line_raddr  = ord_rdata_q;
				store_raddr = {ord_rdata_q, read_off_q};
				state_d     = ST_RD_OUT;
			end
			ST_RD_OUT: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// memories
	always_ff @(posedge clk) begin
		if (store_we)
			store_mem[store_waddr] <= item.in_byte;
		store_rdata_q <= store_mem[store_raddr];
	end

	always_ff @(posedge clk) begin
		if (meta_we) begin
			len_mem[line_count_q[LW-1:0]] <= new_len;
			key_mem[line_count_q[LW-1:0]] <= key_d;
		end
		len_rdata_q <= len_mem[line_raddr];
		key_rdata_q <= key_mem[line_raddr];
	end

	always_ff @(posedge clk) begin
		if (ord_we)
			ord_mem[ord_waddr] <= ord_wdata;
		ord_rdata_q <= ord_mem[ord_raddr];
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			numeric_q <= 1'b0;
			reverse_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_NUMERIC: numeric_q <= cfg_wdata[0];
				CFG_REVERSE: reverse_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// line bookkeeping, readout position and result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_count_q <= '0;
			line_open_q  <= 1'b0;
			sorted_q     <= 1'b0;
			ovf_q        <= 1'b0;
			read_line_q  <= '0;
			read_off_q   <= '0;
			res_v_q      <= 1'b0;
		end else begin
			if (res_v_q && result.ready)
				res_v_q <= 1'b0;
			if (do_load) begin
				sorted_q    <= 1'b0;
				read_line_q <= '0;
				read_off_q  <= '0;
				res_v_q     <= 1'b1;
				if (line_count_q >= CNT_W'(MAX_LINES)) begin
					ovf_q <= 1'b1;
				end else begin
					if (!room)
						ovf_q <= 1'b1;
					if (item.end_of_line) begin
						line_open_q  <= 1'b0;
						line_count_q <= line_count_q + CNT_W'(1);
					end else begin
						line_open_q <= 1'b1;
					end
				end
			end
			if (do_fetch && line_open_q) begin
				line_open_q  <= 1'b0;
				line_count_q <= line_count_q + CNT_W'(1);
			end
			if (state_q == ST_S_CUR && i_q == line_count_q) begin
				sorted_q    <= 1'b1;
				read_line_q <= '0;
				read_off_q  <= '0;
			end
			if (state_q == ST_RD_ORD && read_line_q >= line_count_q)
				res_v_q <= 1'b1;
			if (state_q == ST_RD_OUT) begin
				res_v_q <= 1'b1;
				if (last_byte) begin
					read_line_q <= read_line_q + CNT_W'(1);
					read_off_q  <= '0;
				end else begin
					read_off_q <= read_off_q + OW'(1);
				end
			end
		end
	end

	// datapath registers without reset
	always_ff @(posedge clk) begin
		if (do_load && store_we) begin
			open_len_q <= new_len;
			kphase_q   <= kphase_d;
			kneg_q     <= kneg_d;
			kmag_q     <= kmag_d;
		end
		if (do_load || (state_q == ST_RD_ORD && read_line_q >= line_count_q)) begin
			res_ov_q   <= 1'b0;
			res_byte_q <= '0;
			res_eol_q  <= 1'b0;
			res_eos_q  <= 1'b0;
		end
		case (state_q)
			ST_IDLE:   i_q <= '0;
			ST_S_CUR2: begin
				cur_len_q <= len_rdata_q;
				cur_key_q <= key_rdata_q;
				j_q       <= i_q[LW-1:0];
			end
			ST_S_PREV: prev_q <= ord_rdata_q;
			ST_S_PREVD: begin
				prev_len_q <= len_rdata_q;
				k_q        <= '0;
				lt_q <= $signed(key_rdata_q) < $signed(cur_key_q);
				gt_q <= $signed(key_rdata_q) > $signed(cur_key_q);
			end
			ST_S_BA: begin
				lt_q <= prev_len_q < cur_len_q;
				gt_q <= prev_len_q > cur_len_q;
			end
			ST_S_BB: byte_a_q <= store_rdata_q;
			ST_S_BC: begin
				lt_q <= fa < fb;
				gt_q <= fa > fb;
				k_q  <= k_q + LEN_W'(1);
			end
			ST_S_DEC: begin
				if (shift_up)
					j_q <= j_q - LW'(1);
			end
			ST_S_PLACE: i_q <= i_q + CNT_W'(1);
			ST_RD_OUT: begin
				res_ov_q   <= 1'b1;
				res_byte_q <= store_rdata_q;
				res_eol_q  <= last_byte;
				res_eos_q  <= last_byte && (read_line_q + CNT_W'(1) >= line_count_q);
			end
			default: ;
		endcase
	end

	`TLS_ASSERT_IMP(a_ready_only_idle, item.ready, state_q == ST_IDLE)
	`TLS_ASSERT_ALWAYS(a_count_bound, line_count_q <= CNT_W'(MAX_LINES))
	`TLS_ASSERT_IMP(a_readout_in_range, state_q == ST_RD_OUT, read_line_q < line_count_q)
	`TLS_ASSERT_NEXT(a_fetch_starts_busy, do_fetch, !item.ready)
	`TLS_ASSERT_IMP(a_sort_before_readout, state_q == ST_RD_LINE, sorted_q)

endmodule
